/* rtl/saa_pkg.sv */
// ----------------------------------------------------------------------------
// saa_pkg
// Shared widths, angle constants, arctangent table and Q30 helpers for the
// solar altitude/azimuth pipeline.
// ----------------------------------------------------------------------------
package saa_pkg;

  // datapath widths
  localparam int ZW       = 27;  // angle, 1/65536 degree, signed
  localparam int SW       = 32;  // sine / cosine / products, signed Q30
  localparam int RW       = 34;  // rotation-mode CORDIC x/y
  localparam int VW       = 36;  // vectoring-mode CORDIC x/y
  localparam int RADW     = 61;  // square root radicand
  localparam int SQ_STEPS = 31;  // root bits
  localparam int ATAN_LEN = 24;

  // angle constants in 1/65536 degree
  localparam logic signed [ZW-1:0] DEG_FULL    = 27'sd23592960;
  localparam logic signed [ZW-1:0] DEG_HALF    = 27'sd11796480;
  localparam logic signed [ZW-1:0] DEG_QUARTER = 27'sd5898240;

  // CORDIC start vector length (1/gain in Q30)
  localparam logic signed [RW-1:0] CORDIC_GAIN = 34'sd652032874;

  // one in Q30
  localparam logic signed [SW:0] Q30_ONE = 33'sd1073741824;

  // register indexes of the configuration port
  localparam logic [1:0] CFG_LATITUDE     = 2'd0;
  localparam logic [1:0] CFG_DAY_OF_YEAR  = 2'd1;
  localparam logic [1:0] CFG_NORTH_OFFSET = 2'd2;

  // atan(2^-i) in 1/65536 degree, rounded
  function automatic logic signed [ZW-1:0] atan_entry(input int idx);
    logic signed [ZW-1:0] v;
    case (idx)
      0:       v = 27'sd2949120;
      1:       v = 27'sd1740967;
      2:       v = 27'sd919879;
      3:       v = 27'sd466945;
      4:       v = 27'sd234379;
      5:       v = 27'sd117304;
      6:       v = 27'sd58666;
      7:       v = 27'sd29335;
      8:       v = 27'sd14668;
      9:       v = 27'sd7334;
      10:      v = 27'sd3667;
      11:      v = 27'sd1833;
      12:      v = 27'sd917;
      13:      v = 27'sd458;
      14:      v = 27'sd229;
      15:      v = 27'sd115;
      16:      v = 27'sd57;
      17:      v = 27'sd29;
      18:      v = 27'sd14;
      19:      v = 27'sd7;
      20:      v = 27'sd4;
      21:      v = 27'sd2;
      22:      v = 27'sd1;
      default: v = '0;
    endcase
    return v;
  endfunction

  // Q30 product with floor rounding
  function automatic logic signed [SW-1:0] qmul(input logic signed [SW-1:0] a,
                                                input logic signed [SW-1:0] b);
    logic signed [2*SW-1:0] p;
    p = a * b;
    return SW'(p >>> 30);
  endfunction

endpackage

/* rtl/saa_cordic_rot.sv */
// ----------------------------------------------------------------------------
// saa_cordic_rot
// Pipelined rotation-mode CORDIC: sine and cosine of an angle in 1/65536
// degree, one iteration per register stage.
// ----------------------------------------------------------------------------
module saa_cordic_rot import saa_pkg::*; #(
  parameter int STAGES = 16
) (
  input  logic                 clk,
  input  logic                 en,
  input  logic signed [ZW-1:0] angle,
  output logic signed [SW-1:0] sin_out,
  output logic signed [SW-1:0] cos_out
);

  localparam int NS = (STAGES < ATAN_LEN) ? STAGES : ATAN_LEN;

  logic signed [ZW-1:0] red;
  logic signed [ZW-1:0] fz;
  logic                 fneg;
  logic signed [RW-1:0] xs [NS];
  logic signed [RW-1:0] ys [NS];
  logic signed [ZW-1:0] zs [NS];
  logic                 ng [NS];

  // reduce to [-180,180)
  always_ff @(posedge clk) begin
    if (en) begin
      if (angle >= DEG_HALF) begin
        red <= angle - DEG_FULL;
      end else if (angle < -DEG_HALF) begin
        red <= angle + DEG_FULL;
      end else begin
        red <= angle;
      end
    end
  end

  // fold into [-90,90] and remember to negate
  always_ff @(posedge clk) begin
    if (en) begin
      if (red > DEG_QUARTER) begin
        fz   <= red - DEG_HALF;
        fneg <= 1'b1;
      end else if (red < -DEG_QUARTER) begin
        fz   <= red + DEG_HALF;
        fneg <= 1'b1;
      end else begin
        fz   <= red;
        fneg <= 1'b0;
      end
    end
  end

  // one micro-rotation per stage
  for (genvar i = 0; i < NS; i++) begin : g_iter
    logic signed [RW-1:0] xi;
    logic signed [RW-1:0] yi;
    logic signed [ZW-1:0] zi;
    logic                 ni;
    if (i == 0) begin : g_first
      assign xi = CORDIC_GAIN;
      assign yi = '0;
      assign zi = fz;
      assign ni = fneg;
    end else begin : g_next
      assign xi = xs[i-1];
      assign yi = ys[i-1];
      assign zi = zs[i-1];
      assign ni = ng[i-1];
    end
    always_ff @(posedge clk) begin
      if (en) begin
        if (!zi[ZW-1]) begin
          xs[i] <= xi - (yi >>> i);
          ys[i] <= yi + (xi >>> i);
          zs[i] <= zi - atan_entry(i);
        end else begin
          xs[i] <= xi + (yi >>> i);
          ys[i] <= yi - (xi >>> i);
          zs[i] <= zi + atan_entry(i);
        end
        ng[i] <= ni;
      end
    end
  end

  // undo the fold
  always_ff @(posedge clk) begin
    if (en) begin
      sin_out <= SW'(ng[NS-1] ? -ys[NS-1] : ys[NS-1]);
      cos_out <= SW'(ng[NS-1] ? -xs[NS-1] : xs[NS-1]);
    end
  end

endmodule

/* rtl/saa_cordic_vec.sv */
// ----------------------------------------------------------------------------
// saa_cordic_vec
// Pipelined vectoring-mode CORDIC: atan2(y, x) in 1/65536 degree, one
// iteration per register stage, atan2(0,0) = 0.
// ----------------------------------------------------------------------------
module saa_cordic_vec import saa_pkg::*; #(
  parameter int STAGES = 16
) (
  input  logic                 clk,
  input  logic                 en,
  input  logic signed [VW-1:0] y_in,
  input  logic signed [VW-1:0] x_in,
  output logic signed [ZW-1:0] z_out
);

  localparam int NS = (STAGES < ATAN_LEN) ? STAGES : ATAN_LEN;

  logic signed [VW-1:0] px;
  logic signed [VW-1:0] py;
  logic signed [ZW-1:0] pz;
  logic                 pzero;
  logic signed [VW-1:0] xs [NS];
  logic signed [VW-1:0] ys [NS];
  logic signed [ZW-1:0] zs [NS];
  logic                 zr [NS];

  // turn left-half vectors by a quarter turn
  always_ff @(posedge clk) begin
    if (en) begin
      pzero <= (x_in == '0) && (y_in == '0);
      if (x_in[VW-1]) begin
        if (!y_in[VW-1]) begin
          px <= y_in;
          py <= -x_in;
          pz <= DEG_QUARTER;
        end else begin
          px <= -y_in;
          py <= x_in;
          pz <= -DEG_QUARTER;
        end
      end else begin
        px <= x_in;
        py <= y_in;
        pz <= '0;
      end
    end
  end

  // drive y toward zero, one step per stage
  for (genvar i = 0; i < NS; i++) begin : g_iter
    logic signed [VW-1:0] xi;
    logic signed [VW-1:0] yi;
    logic signed [ZW-1:0] zi;
    logic                 ri;
    if (i == 0) begin : g_first
      assign xi = px;
      assign yi = py;
      assign zi = pz;
      assign ri = pzero;
    end else begin : g_next
      assign xi = xs[i-1];
      assign yi = ys[i-1];
      assign zi = zs[i-1];
      assign ri = zr[i-1];
    end
    always_ff @(posedge clk) begin
      if (en) begin
        if (!yi[VW-1]) begin
          xs[i] <= xi + (yi >>> i);
          ys[i] <= yi - (xi >>> i);
          zs[i] <= zi + atan_entry(i);
        end else begin
          xs[i] <= xi - (yi >>> i);
          ys[i] <= yi + (xi >>> i);
          zs[i] <= zi - atan_entry(i);
        end
        zr[i] <= ri;
      end
    end
  end

  // force zero for the null vector
  always_ff @(posedge clk) begin
    if (en) begin
      z_out <= zr[NS-1] ? '0 : zs[NS-1];
    end
  end

endmodule

/* rtl/saa_isqrt.sv */
// ----------------------------------------------------------------------------
// saa_isqrt
// Pipelined floor integer square root, one root bit per register stage.
// ----------------------------------------------------------------------------
module saa_isqrt import saa_pkg::*; (
  input  logic                clk,
  input  logic                en,
  input  logic [RADW-1:0]     rad,
  output logic [SQ_STEPS-1:0] root
);

  localparam int RTW = RADW + 1;

  logic [RTW-1:0] vs [SQ_STEPS];
  logic [RTW-1:0] rs [SQ_STEPS];

  for (genvar k = 0; k < SQ_STEPS; k++) begin : g_step
    localparam logic [RTW-1:0] B = RTW'(1) << (2 * (SQ_STEPS - 1 - k));
    logic [RTW-1:0] vi;
    logic [RTW-1:0] ri;
    if (k == 0) begin : g_first
      assign vi = RTW'(rad);
      assign ri = '0;
    end else begin : g_next
      assign vi = vs[k-1];
      assign ri = rs[k-1];
    end
    // trial subtract of the next root bit
    always_ff @(posedge clk) begin
      if (en) begin
        if (vi >= ri + B) begin
          vs[k] <= vi - (ri + B);
          rs[k] <= (ri >> 1) + B;
        end else begin
          vs[k] <= vi;
          rs[k] <= ri >> 1;
        end
      end
    end
  end

  assign root = rs[SQ_STEPS-1][SQ_STEPS-1:0];

endmodule

/* rtl/solar_altitude_azimuth.sv */
// ----------------------------------------------------------------------------
// solar_altitude_azimuth
// Sun pitch and yaw from time of day, latitude, day of year and north offset.
// ----------------------------------------------------------------------------
// Fully pipelined: one time-of-day beat enters per clock while in_stall is
// low. The pipeline depth is set by the chain of pipelined CORDIC units
// (day-angle sine, then declination sine and cosine, then the two atan2
// units) and the 31-stage square root that forms the altitude cosine. A
// stall on the output freezes the pipeline once a beat meets the blocked
// output; a two-entry output buffer keeps beats from being lost.
// Write configuration only while no beat is in flight.
module solar_altitude_azimuth import saa_pkg::*; #(
  parameter int CORDIC_STAGES = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_write,
  input  logic [1:0]         cfg_index,
  input  logic [16:0]        cfg_data,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [16:0]        time_of_day,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [15:0] sun_pitch,
  output logic signed [17:0] sun_yaw
);

  localparam int NSTG     = (CORDIC_STAGES < ATAN_LEN) ? CORDIC_STAGES : ATAN_LEN;
  localparam int LROT     = NSTG + 3;
  localparam int LVEC     = NSTG + 2;
  localparam int LDEC     = 4;
  localparam int DLY_TRIG = LDEC + LROT;
  localparam int DLY_ATAN = 2 + SQ_STEPS;
  localparam int TOT      = 3 + LROT + LDEC + LROT + 5 + SQ_STEPS + LVEC + 2;

  localparam logic signed [ZW-1:0] HOUR_SCALE = 27'sd240;

  typedef struct packed {
    logic signed [SW-1:0] sl;
    logic signed [SW-1:0] cl;
    logic signed [SW-1:0] sh;
    logic signed [SW-1:0] ch;
  } trig_t;

  typedef struct packed {
    logic signed [SW-1:0] salt;
    logic signed [SW-1:0] saz;
    logic signed [SW:0]   caz;
  } atan_in_t;

  // configuration registers
  logic signed [15:0] latitude;
  logic [8:0]         day_of_year;
  logic signed [16:0] north_offset;

  logic           en;
  logic [TOT-1:0] vpipe;

  always_ff @(posedge clk) begin
    if (rst) begin
      latitude     <= 16'sd11520;
      day_of_year  <= 9'd100;
      north_offset <= '0;
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_LATITUDE:     latitude     <= cfg_data[15:0];
        CFG_DAY_OF_YEAR:  day_of_year  <= cfg_data[8:0];
        CFG_NORTH_OFFSET: north_offset <= cfg_data;
        default:          ;
      endcase
    end
  end

  // valid bits travel beside the data
  always_ff @(posedge clk) begin
    if (rst) begin
      vpipe <= '0;
    end else if (en) begin
      vpipe <= {vpipe[TOT-2:0], in_valid};
    end
  end

  // ---------------- angle preparation ----------------
  logic signed [17:0] t_c;
  logic signed [9:0]  m_c;
  logic [8:0]         am_c;
  logic signed [ZW-1:0] ha1, lat1, ha2, lat2, ha3, lat3, darg3;
  logic [24:0] q1, q2;
  logic [17:0] r1;
  logic        neg1, neg2;
  logic [35:0] prod2;

  always_comb begin
    t_c  = $signed({1'b0, time_of_day}) - 18'sd49152;
    m_c  = $signed({1'b0, day_of_year}) - 10'sd81;
    am_c = m_c[9] ? 9'(-m_c) : m_c[8:0];
  end

  // hour angle, latitude angle, split (day-81)*360/365
  always_ff @(posedge clk) begin
    if (en) begin
      ha1  <= ZW'(t_c) * HOUR_SCALE;
      lat1 <= ZW'($signed({latitude, 8'h00}));
      q1   <= 25'(am_c) * 25'd64638;
      r1   <= 18'(am_c) * 18'd90;
      neg1 <= m_c[9];
    end
  end

  // remainder part divided by 365 through a reciprocal
  always_ff @(posedge clk) begin
    if (en) begin
      prod2 <= 36'(r1 + 18'd182) * 36'd183860;
      q2    <= q1;
      neg2  <= neg1;
      ha2   <= ha1;
      lat2  <= lat1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      darg3 <= neg2 ? -$signed({2'b00, q2 + 25'(prod2 >> 26)})
                    :  $signed({2'b00, q2 + 25'(prod2 >> 26)});
      ha3   <= ha2;
      lat3  <= lat2;
    end
  end

  // ---------------- first sine/cosine bank ----------------
  logic signed [SW-1:0] sl, cl, sdec, sh, ch;

  saa_cordic_rot #(.STAGES(CORDIC_STAGES)) u_rot_lat (
    .clk(clk), .en(en), .angle(lat3), .sin_out(sl), .cos_out(cl)
  );

  saa_cordic_rot #(.STAGES(CORDIC_STAGES)) u_rot_darg (
    .clk(clk), .en(en), .angle(darg3), .sin_out(sdec), .cos_out()
  );

  saa_cordic_rot #(.STAGES(CORDIC_STAGES)) u_rot_hour (
    .clk(clk), .en(en), .angle(ha3), .sin_out(sh), .cos_out(ch)
  );

  // ---------------- declination scaling ----------------
  logic [SW-1:0]   sabs;
  logic [42:0]     nabs1;
  logic            nneg1, nneg2, nneg3;
  logic [26:0]     v2;
  logic [55:0]     prod3;
  logic signed [ZW-1:0] decl4;

  assign sabs = sdec[SW-1] ? SW'(-sdec) : SW'(sdec);

  always_ff @(posedge clk) begin
    if (en) begin
      nabs1 <= 43'(sabs) * 43'd2345;
      nneg1 <= sdec[SW-1];
      v2    <= 27'((nabs1 + 43'd819200) >> 16);
      nneg2 <= nneg1;
      prod3 <= 56'(v2) * 56'd171798692;
      nneg3 <= nneg2;
      decl4 <= nneg3 ? -$signed({3'b000, prod3[55:32]})
                     :  $signed({3'b000, prod3[55:32]});
    end
  end

  // ---------------- declination sine/cosine ----------------
  logic signed [SW-1:0] sd, cd;

  saa_cordic_rot #(.STAGES(CORDIC_STAGES)) u_rot_decl (
    .clk(clk), .en(en), .angle(decl4), .sin_out(sd), .cos_out(cd)
  );

  // hold first-bank results until the declination terms arrive
  trig_t trig_dly [DLY_TRIG];
  trig_t trig;

  always_ff @(posedge clk) begin
    if (en) begin
      trig_dly[0] <= '{sl: sl, cl: cl, sh: sh, ch: ch};
      for (int k = 1; k < DLY_TRIG; k++) begin
        trig_dly[k] <= trig_dly[k-1];
      end
    end
  end

  assign trig = trig_dly[DLY_TRIG-1];

  // ---------------- spherical products ----------------
  logic signed [SW-1:0] psl_sd, pcl_cd, psl_cd, pcl_sd, pcd_sh, ch1;
  logic signed [SW-1:0] a2, b2, saz2, psl_sd2, pcl_sd2;
  logic signed [SW:0]   sum_c, caz3;
  logic signed [SW-1:0] salt3, saz3;
  logic signed [2*SW-1:0] salt_w;
  logic [RADW-1:0]      sq4, rad5;

  always_ff @(posedge clk) begin
    if (en) begin
      psl_sd  <= qmul(trig.sl, sd);
      pcl_cd  <= qmul(trig.cl, cd);
      psl_cd  <= qmul(trig.sl, cd);
      pcl_sd  <= qmul(trig.cl, sd);
      pcd_sh  <= qmul(cd, trig.sh);
      ch1     <= trig.ch;
      a2      <= qmul(pcl_cd, ch1);
      b2      <= qmul(psl_cd, ch1);
      saz2    <= -pcd_sh;
      psl_sd2 <= psl_sd;
      pcl_sd2 <= pcl_sd;
    end
  end

  assign sum_c  = {psl_sd2[SW-1], psl_sd2} + {a2[SW-1], a2};
  assign salt_w = (2*SW)'(salt3);

  // clamp the altitude sine, then square and form 1 - s^2
  always_ff @(posedge clk) begin
    if (en) begin
      if (sum_c > Q30_ONE) begin
        salt3 <= SW'(Q30_ONE);
      end else if (sum_c < -Q30_ONE) begin
        salt3 <= SW'(-Q30_ONE);
      end else begin
        salt3 <= SW'(sum_c);
      end
      caz3 <= {pcl_sd2[SW-1], pcl_sd2} - {b2[SW-1], b2};
      saz3 <= saz2;
      sq4  <= RADW'(salt_w * salt_w);
      rad5 <= (RADW'(1) << 60) - sq4;
    end
  end

  logic [SQ_STEPS-1:0] calt;

  saa_isqrt u_isqrt (
    .clk(clk), .en(en), .rad(rad5), .root(calt)
  );

  // hold atan2 operands across the square root
  atan_in_t atan_dly [DLY_ATAN];
  atan_in_t av;

  always_ff @(posedge clk) begin
    if (en) begin
      atan_dly[0] <= '{salt: salt3, saz: saz3, caz: caz3};
      for (int k = 1; k < DLY_ATAN; k++) begin
        atan_dly[k] <= atan_dly[k-1];
      end
    end
  end

  assign av = atan_dly[DLY_ATAN-1];

  // ---------------- atan2 pair ----------------
  logic signed [VW-1:0] alt_y, alt_x, az_y, az_x;
  logic signed [ZW-1:0] alt_z, az_z;

  assign alt_y = VW'(av.salt);
  assign alt_x = VW'(calt);
  assign az_y  = VW'(av.saz);
  assign az_x  = VW'(av.caz);

  saa_cordic_vec #(.STAGES(CORDIC_STAGES)) u_vec_alt (
    .clk(clk), .en(en), .y_in(alt_y), .x_in(alt_x), .z_out(alt_z)
  );

  saa_cordic_vec #(.STAGES(CORDIC_STAGES)) u_vec_az (
    .clk(clk), .en(en), .y_in(az_y), .x_in(az_x), .z_out(az_z)
  );

  // ---------------- rounding and output forming ----------------
  logic [ZW-1:0]      alt_abs, az_abs;
  logic [18:0]        alt_mag, az_mag;
  logic               alt_neg, az_neg;
  logic signed [19:0] alt_s, az_s;
  logic signed [15:0] pitch_c;
  logic signed [17:0] yaw_c;
  logic signed [16:0] az_c;

  assign alt_abs = alt_z[ZW-1] ? ZW'(-alt_z) : ZW'(alt_z);
  assign az_abs  = az_z[ZW-1]  ? ZW'(-az_z)  : ZW'(az_z);

  // round half away from zero to 1/256 degree
  always_ff @(posedge clk) begin
    if (en) begin
      alt_mag <= 19'((alt_abs + ZW'(128)) >> 8);
      alt_neg <= alt_z[ZW-1];
      az_mag  <= 19'((az_abs + ZW'(128)) >> 8);
      az_neg  <= az_z[ZW-1];
    end
  end

  always_comb begin
    alt_s = alt_neg ? -$signed({1'b0, alt_mag}) : $signed({1'b0, alt_mag});
    az_s  = az_neg  ? -$signed({1'b0, az_mag})  : $signed({1'b0, az_mag});
    if (alt_s > 20'sd23040) begin
      pitch_c = -16'sd23040;
    end else if (alt_s < -20'sd23040) begin
      pitch_c = 16'sd23040;
    end else begin
      pitch_c = -16'(alt_s);
    end
    if (az_s > 20'sd46080) begin
      az_c = 17'sd46080;
    end else if (az_s < -20'sd46080) begin
      az_c = -17'sd46080;
    end else begin
      az_c = 17'(az_s);
    end
    yaw_c = 18'(az_c) + 18'(north_offset);
  end

  logic signed [15:0] pitch_f;
  logic signed [17:0] yaw_f;

  always_ff @(posedge clk) begin
    if (en) begin
      pitch_f <= pitch_c;
      yaw_f   <= yaw_c;
    end
  end

  // ---------------- output register and skid ----------------
  logic               skid_v;
  logic signed [15:0] skid_pitch;
  logic signed [17:0] skid_yaw;

  assign en       = !skid_v;
  assign in_stall = skid_v;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      skid_v    <= 1'b0;
    end else if (!out_valid || !out_stall) begin
      if (skid_v) begin
        out_valid <= 1'b1;
        skid_v    <= 1'b0;
      end else begin
        out_valid <= vpipe[TOT-1];
      end
    end else if (en && vpipe[TOT-1]) begin
      skid_v <= 1'b1;
    end
  end

  // move payload with the beat
  always_ff @(posedge clk) begin
    if (!out_valid || !out_stall) begin
      if (skid_v) begin
        sun_pitch <= skid_pitch;
        sun_yaw   <= skid_yaw;
      end else begin
        sun_pitch <= pitch_f;
        sun_yaw   <= yaw_f;
      end
    end else if (en) begin
      skid_pitch <= pitch_f;
      skid_yaw   <= yaw_f;
    end
  end

  // ---------------- checks ----------------
  a_skid_needs_out: assert property (@(posedge clk) disable iff (rst)
    skid_v |-> out_valid)
    else $error("skid entry held while output register empty");

  a_skid_holds: assert property (@(posedge clk) disable iff (rst)
    (skid_v && out_valid && out_stall) |=> skid_v)
    else $error("skid entry dropped while output blocked");

  a_pitch_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (sun_pitch <= 16'sd23040 && sun_pitch >= -16'sd23040))
    else $error("pitch outside clamp range");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> (!out_valid && !skid_v))
    else $error("output not empty after reset");

endmodule
